FILE: rtl/clb_pkg.sv
// Package with the constants, types and request codes of the line-edit buffer.
package clb_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int REQ_W    = 3;
    localparam int CHAR_W   = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_LEFT   = 3'd0,
        REQ_RIGHT  = 3'd1,
        REQ_BACK   = 3'd2,
        REQ_INSERT = 3'd3,
        REQ_DUMP   = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INS,
        OP_SHL
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [IDX_W-1:0]  pos;
        logic              wrap_en;
        logic [IDX_W-1:0]  wrap_pos;
        logic [CHAR_W-1:0] data;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

endpackage

FILE: rtl/clb_if.sv
// Handshake interfaces for request words and result words.
interface clb_in_if;
    logic                         valid;
    logic                         ready;
    logic [clb_pkg::REQ_W-1:0]    req_type;
    logic [clb_pkg::CHAR_W-1:0]   char_in;

    modport source (output valid, output req_type, output char_in, input ready);
    modport sink (input valid, input req_type, input char_in, output ready);
endinterface

interface clb_out_if;
    logic                         valid;
    logic                         ready;
    logic [clb_pkg::CHAR_W-1:0]   char_out;
    logic                         last;
    logic                         empty_res;
    logic                         overflowed;

    modport source (output valid, output char_out, output last, output empty_res,
                    output overflowed, input ready);
    modport sink (input valid, input char_out, input last, input empty_res,
                  input overflowed, output ready);
endinterface

FILE: rtl/cursor_line_edit_buffer_core.sv
// Top level of the line-edit buffer: request sequencer and the chain of text cells.
//
// Requests arrive as words on i_req (req_type, char_in) and results leave as words
// on o_res (char_out, last, empty_res, overflowed), both valid/ready handshakes.
// The text is held in a row of byte cells in text order; the cursor is a count.
// Cursor moves, backspace and insert give no result word.
// An insert into a full buffer is dropped and sets the sticky overflow flag.
// A dump emits one word per character, with the chain rotating one cell toward
// the front per emitted word; an empty buffer gives a single word with empty_res
// and last set. The text is unchanged after a dump, since the rotation closes the
// ring exactly once.
// Words reach o_res through an output register, so edits are accepted while a
// result word still waits. While a dump is in progress i_req is not ready, and
// when o_res stalls the rotation simply pauses.
// After reset the buffer is empty, the cursor is at the start and the overflow
// flag is clear; the cell contents need no reset.
module cursor_line_edit_buffer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    clb_in_if.sink    i_req,
    clb_out_if.source o_res
);

    logic [clb_pkg::CNT_W-1:0]  r_before;
    logic [clb_pkg::CNT_W-1:0]  n_before;
    logic [clb_pkg::CNT_W-1:0]  r_total;
    logic [clb_pkg::CNT_W-1:0]  n_total;
    logic [clb_pkg::CNT_W-1:0]  r_cnt;
    logic [clb_pkg::CNT_W-1:0]  n_cnt;
    logic                       r_ovf;
    logic                       n_ovf;
    clb_pkg::t_state            r_state;
    clb_pkg::t_state            n_state;

    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [clb_pkg::CHAR_W-1:0]  r_out_char;
    logic [clb_pkg::CHAR_W-1:0]  n_out_char;
    logic                        r_out_last;
    logic                        n_out_last;
    logic                        r_out_empty;
    logic                        n_out_empty;
    logic                        r_out_ovf;
    logic                        n_out_ovf;

    clb_pkg::t_cell_ctl          w_ctl;
    logic                        w_accept;
    logic                        w_load;
    logic                        w_is_last;
    logic [clb_pkg::CNT_W-1:0]   w_cnt_inc;
    logic [clb_pkg::CNT_W-1:0]   w_total_dec;
    logic [clb_pkg::CNT_W-1:0]   w_before_dec;
    logic [clb_pkg::CHAR_W-1:0]  w_cell  [clb_pkg::CAPACITY];
    logic [clb_pkg::CHAR_W-1:0]  w_left  [clb_pkg::CAPACITY];
    logic [clb_pkg::CHAR_W-1:0]  w_right [clb_pkg::CAPACITY];

    function automatic logic [clb_pkg::CNT_W-1:0] w_cnt_inc_before(
        input logic [clb_pkg::CNT_W-1:0] i_val
    );
        return i_val + 1'b1;
    endfunction

    assign i_req.ready = (r_state == clb_pkg::ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_load      = (r_state == clb_pkg::ST_DUMP) && (!r_out_valid || o_res.ready);
    assign w_cnt_inc    = r_cnt + 1'b1;
    assign w_total_dec  = r_total - 1'b1;
    assign w_before_dec = r_before - 1'b1;
    assign w_is_last    = (r_total == '0) || (w_cnt_inc == r_total);

    always_comb begin
        n_before    = r_before;
        n_total     = r_total;
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_empty = r_out_empty;
        n_out_ovf   = r_out_ovf;
        w_ctl.op       = clb_pkg::OP_HOLD;
        w_ctl.pos      = '0;
        w_ctl.wrap_en  = 1'b0;
        w_ctl.wrap_pos = '0;
        w_ctl.data     = i_req.char_in;

        unique case (r_state)
            clb_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.req_type)
                        clb_pkg::REQ_LEFT: begin
                            if (r_before != '0) begin
                                n_before = w_before_dec;
                            end
                        end
                        clb_pkg::REQ_RIGHT: begin
                            if (r_before < r_total) begin
                                n_before = w_cnt_inc_before(r_before);
                            end
                        end
                        clb_pkg::REQ_BACK: begin
                            if (r_before != '0) begin
                                w_ctl.op  = clb_pkg::OP_SHL;
                                w_ctl.pos = w_before_dec[clb_pkg::IDX_W-1:0];
                                n_before  = w_before_dec;
                                n_total   = w_total_dec;
                            end
                        end
                        clb_pkg::REQ_INSERT: begin
                            if (r_total < clb_pkg::CNT_W'(clb_pkg::CAPACITY)) begin
                                w_ctl.op  = clb_pkg::OP_INS;
                                w_ctl.pos = r_before[clb_pkg::IDX_W-1:0];
                                n_before  = w_cnt_inc_before(r_before);
                                n_total   = r_total + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        clb_pkg::REQ_DUMP: begin
                            n_cnt   = '0;
                            n_state = clb_pkg::ST_DUMP;
                        end
                        default: begin
                            n_state = clb_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            clb_pkg::ST_DUMP: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_last  = w_is_last;
                    n_out_empty = (r_total == '0);
                    n_out_char  = (r_total == '0) ? '0 : w_cell[0];
                    n_out_ovf   = r_ovf;
                    n_cnt       = w_cnt_inc;
                    if (r_total != '0) begin
                        w_ctl.op       = clb_pkg::OP_SHL;
                        w_ctl.pos      = '0;
                        w_ctl.wrap_en  = 1'b1;
                        w_ctl.wrap_pos = w_total_dec[clb_pkg::IDX_W-1:0];
                    end
                    if (w_is_last) begin
                        n_state = clb_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = clb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clb_pkg::ST_IDLE;
            r_before    <= '0;
            r_total     <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_before    <= n_before;
            r_total     <= n_total;
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_char  <= n_out_char;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_ovf   <= n_out_ovf;
    end

    for (genvar g = 0; g < clb_pkg::CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = w_cell[g];
        end else begin : g_body
            assign w_left[g] = w_cell[g-1];
        end
        if (g == clb_pkg::CAPACITY - 1) begin : g_tail
            assign w_right[g] = w_cell[0];
        end else begin : g_inner
            assign w_right[g] = w_cell[g+1];
        end

        clb_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (clb_pkg::IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_first (w_cell[0]),
            .o_data  (w_cell[g])
        );
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.char_out   = r_out_char;
    assign o_res.last       = r_out_last;
    assign o_res.empty_res  = r_out_empty;
    assign o_res.overflowed = r_out_ovf;

    a_cursor_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_before <= r_total)
        else $error("Cursor is past the end of the text.");

    a_total_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= clb_pkg::CNT_W'(clb_pkg::CAPACITY))
        else $error("Text length exceeds the buffer capacity.");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_ovf))
        else $error("Overflow flag cleared without reset.");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_empty |-> r_out_last)
        else $error("Empty dump word is not marked last.");

    a_dump_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_is_last |=> (r_state == clb_pkg::ST_IDLE) && r_out_valid)
        else $error("Dump did not finish after its last word.");

endmodule

FILE: rtl/clb_cell.sv
// One character cell of the text chain, trading its byte with its neighbors.
module clb_cell (
    input  logic                          i_clk,
    input  logic [clb_pkg::IDX_W-1:0]     i_idx,
    input  clb_pkg::t_cell_ctl            i_ctl,
    input  logic [clb_pkg::CHAR_W-1:0]    i_left,
    input  logic [clb_pkg::CHAR_W-1:0]    i_right,
    input  logic [clb_pkg::CHAR_W-1:0]    i_first,
    output logic [clb_pkg::CHAR_W-1:0]    o_data
);

    logic [clb_pkg::CHAR_W-1:0] r_data;
    logic [clb_pkg::CHAR_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.op)
            clb_pkg::OP_INS: begin
                if (i_idx == i_ctl.pos) begin
                    n_data = i_ctl.data;
                end else if (i_idx > i_ctl.pos) begin
                    n_data = i_left;
                end
            end
            clb_pkg::OP_SHL: begin
                if (i_ctl.wrap_en && (i_idx == i_ctl.wrap_pos)) begin
                    n_data = i_first;
                end else if (i_idx >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: tb/clb_tb_pkg.sv
// Scoreboard class that tracks the text and checks the result words of the line-edit buffer.
package clb_tb_pkg;

    typedef struct packed {
        logic [clb_pkg::CHAR_W-1:0] ch;
        logic                       last;
        logic                       empty;
        logic                       ovf;
    } t_res_word;

    class gap_text_tracker;
        logic [clb_pkg::CHAR_W-1:0] cells [clb_pkg::CAPACITY];
        logic [clb_pkg::CNT_W-1:0]  before_n;
        logic [clb_pkg::CNT_W-1:0]  after_n;
        logic                       overflow;
        t_res_word                  expected_words [$];
        int unsigned                errors;
        int unsigned                dumps;
        int unsigned                words_checked;
        int unsigned                fills;

        function new();
            foreach (cells[i]) cells[i] = '0;
            before_n      = '0;
            after_n       = '0;
            overflow      = 1'b0;
            errors        = 0;
            dumps         = 0;
            words_checked = 0;
            fills         = 0;
        endfunction

        function int unsigned text_len();
            return before_n + after_n;
        endfunction

        // Update the text for one accepted request and queue the words a dump gives.
        function void note_request(logic [clb_pkg::REQ_W-1:0] req,
                                   logic [clb_pkg::CHAR_W-1:0] ch);
            int unsigned total;
            t_res_word   w;
            total = before_n + after_n;
            case (req)
                clb_pkg::REQ_LEFT: begin
                    if (before_n > 0) begin
                        cells[clb_pkg::CAPACITY - after_n - 1] = cells[before_n - 1];
                        before_n = before_n - 1'b1;
                        after_n  = after_n + 1'b1;
                    end
                end
                clb_pkg::REQ_RIGHT: begin
                    if (after_n > 0) begin
                        cells[before_n] = cells[clb_pkg::CAPACITY - after_n];
                        before_n = before_n + 1'b1;
                        after_n  = after_n - 1'b1;
                    end
                end
                clb_pkg::REQ_BACK: begin
                    if (before_n > 0) before_n = before_n - 1'b1;
                end
                clb_pkg::REQ_INSERT: begin
                    if (total < clb_pkg::CAPACITY) begin
                        cells[before_n] = ch;
                        before_n = before_n + 1'b1;
                        if (total + 1 == clb_pkg::CAPACITY) fills++;
                    end else begin
                        overflow = 1'b1;
                    end
                end
                clb_pkg::REQ_DUMP: begin
                    dumps++;
                    w.ovf = overflow;
                    if (total == 0) begin
                        w.ch    = '0;
                        w.last  = 1'b1;
                        w.empty = 1'b1;
                        expected_words.push_back(w);
                    end else begin
                        for (int i = 0; i < total; i++) begin
                            if (i < before_n) begin
                                w.ch = cells[i];
                            end else begin
                                w.ch = cells[clb_pkg::CAPACITY - after_n + (i - before_n)];
                            end
                            w.last  = (i + 1 == total);
                            w.empty = 1'b0;
                            expected_words.push_back(w);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v) begin
                errors++;
                $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            end
        endfunction

        function void check_word(t_res_word got);
            t_res_word exp_w;
            if (expected_words.size() == 0) begin
                errors++;
                $error("char_out: expected no word, got %0h", got.ch);
                return;
            end
            exp_w = expected_words.pop_front();
            words_checked++;
            compare_field("char_out", 32'(exp_w.ch), 32'(got.ch));
            compare_field("last", 32'(exp_w.last), 32'(got.last));
            compare_field("empty_res", 32'(exp_w.empty), 32'(got.empty));
            compare_field("overflowed", 32'(exp_w.ovf), 32'(got.ovf));
        endfunction
    endclass

endpackage

FILE: tb/tb_cursor_line_edit_buffer_core.sv
// Testbench top for the line-edit buffer: drives edit and dump requests, checks the dumps.
module tb_cursor_line_edit_buffer_core;

    localparam int RANDOM_ITEMS   = 220;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_TAIL     = 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int IDLE_PCT       = 29;

    logic i_clk;
    logic i_rst_n;

    clb_in_if  req_if ();
    clb_out_if res_if ();

    cursor_line_edit_buffer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    clb_tb_pkg::gap_text_tracker text_board;
    clb_tb_pkg::t_res_word       res_seen;
    bit                          idle_on;
    int                          holds_asked;
    int                          holds_served;
    int                          items_sent;
    int                          quiet_cycles;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            res_seen.ch    = res_if.char_out;
            res_seen.last  = res_if.last;
            res_seen.empty = res_if.empty_res;
            res_seen.ovf   = res_if.overflowed;
            text_board.check_word(res_seen);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : res_side
        int stall_left;
        stall_left   = 0;
        holds_served = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && holds_asked != holds_served) begin
                holds_served++;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready = 1'b0;
            end else begin
                res_if.ready = !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    function automatic logic [clb_pkg::CHAR_W-1:0] rand_char();
        return clb_pkg::CHAR_W'($urandom);
    endfunction

    // Called and returning at a falling edge; valid stays high for a following word.
    task automatic send_word(input logic [clb_pkg::REQ_W-1:0] req,
                             input logic [clb_pkg::CHAR_W-1:0] ch);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid    = 1'b1;
        req_if.req_type = req;
        req_if.char_in  = ch;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        text_board.note_request(req, ch);
        if (req <= clb_pkg::REQ_DUMP) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (text_board.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic edit_burst();
        int n;
        int pick;
        n = $urandom_range(20, 6);
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 40) send_word(clb_pkg::REQ_INSERT, rand_char());
            else if (pick < 55) send_word(clb_pkg::REQ_LEFT, rand_char());
            else if (pick < 70) send_word(clb_pkg::REQ_RIGHT, rand_char());
            else if (pick < 85) send_word(clb_pkg::REQ_BACK, rand_char());
            else if (pick < 95) send_word(clb_pkg::REQ_DUMP, rand_char());
            else send_word(clb_pkg::REQ_W'($urandom_range(2**clb_pkg::REQ_W - 1,
                                                          clb_pkg::REQ_DUMP + 1)),
                           rand_char());
        end
        send_word(clb_pkg::REQ_DUMP, rand_char());
    endtask

    task automatic fill_to_overflow(input bit with_hold);
        int extra;
        while (text_board.text_len() < clb_pkg::CAPACITY) begin
            if ($urandom_range(9) == 0) send_word(clb_pkg::REQ_LEFT, rand_char());
            else send_word(clb_pkg::REQ_INSERT, rand_char());
        end
        extra = $urandom_range(3, 1);
        repeat (extra) send_word(clb_pkg::REQ_INSERT, rand_char());
        if (with_hold) holds_asked++;
        send_word(clb_pkg::REQ_DUMP, rand_char());
        if (with_hold) begin
            repeat (10) begin
                send_word(clb_pkg::REQ_W'($urandom_range(clb_pkg::REQ_BACK,
                                                         clb_pkg::REQ_LEFT)),
                          rand_char());
            end
            send_word(clb_pkg::REQ_DUMP, rand_char());
            wait_drained();
        end
    endtask

    task automatic clear_text();
        while (text_board.after_n != 0) send_word(clb_pkg::REQ_RIGHT, rand_char());
        while (text_board.before_n != 0) send_word(clb_pkg::REQ_BACK, rand_char());
        send_word(clb_pkg::REQ_BACK, rand_char());
        send_word(clb_pkg::REQ_DUMP, rand_char());
    endtask

    initial begin : stimulus
        int ep;
        int pick;
        text_board      = new();
        idle_on         = 1'b1;
        holds_asked     = 0;
        items_sent      = 0;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.req_type = clb_pkg::REQ_LEFT;
        req_if.char_in  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_word(clb_pkg::REQ_DUMP, 8'h00);
        send_word(clb_pkg::REQ_LEFT, 8'h00);
        send_word(clb_pkg::REQ_RIGHT, 8'hFF);
        send_word(clb_pkg::REQ_BACK, 8'h00);
        send_word(clb_pkg::REQ_INSERT, 8'h00);
        send_word(clb_pkg::REQ_INSERT, 8'hFF);
        send_word(clb_pkg::REQ_INSERT, "L");
        send_word(clb_pkg::REQ_INSERT, "D");
        send_word(clb_pkg::REQ_INSERT, "B");
        send_word(clb_pkg::REQ_DUMP, 8'hFF);
        send_word(clb_pkg::REQ_LEFT, 8'h00);
        send_word(clb_pkg::REQ_LEFT, 8'h00);
        send_word(clb_pkg::REQ_INSERT, 8'hA5);
        send_word(clb_pkg::REQ_RIGHT, 8'h00);
        send_word(clb_pkg::REQ_RIGHT, 8'h00);
        send_word(clb_pkg::REQ_RIGHT, 8'h00);
        send_word(clb_pkg::REQ_BACK, 8'h00);
        send_word(clb_pkg::REQ_DUMP, 8'h00);
        for (int c = clb_pkg::REQ_DUMP + 1; c < 2**clb_pkg::REQ_W; c++) begin
            send_word(clb_pkg::REQ_W'(c), 8'h5A);
        end
        send_word(clb_pkg::REQ_DUMP, 8'h00);

        edit_burst();
        fill_to_overflow(1'b1);
        ep = 0;
        while (items_sent < RANDOM_ITEMS) begin
            idle_on = !(ep >= 3 && ep < 8);
            pick = $urandom_range(99);
            if (pick < 70) edit_burst();
            else if (pick < 85) fill_to_overflow(1'b0);
            else clear_text();
            ep++;
        end
        idle_on = 1'b1;
        wait_drained();

        $display("ran %0d requests with %0d dumps; checked %0d result words",
                 items_sent, text_board.dumps, text_board.words_checked);
        $display("buffer reached capacity %0d times; overflow flag ended at %0b",
                 text_board.fills, text_board.overflow);
        if (text_board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/clb_pkg.sv
rtl/clb_if.sv
rtl/clb_cell.sv
rtl/cursor_line_edit_buffer_core.sv
tb/clb_tb_pkg.sv
tb/tb_cursor_line_edit_buffer_core.sv
